/* src/pcmc_pkg.sv */
// Shared types and constants for the pay-and-change minimum coin block.
`default_nettype none

package pcmc_pkg;

  localparam int AMOUNT_LIMIT_DEFAULT = 500;
  localparam int CENTS_PER_UNIT       = 5;
  localparam int NUM_DENOMS           = 6;
  localparam int PAY_W                = 8;
  localparam int CNT_W                = 7;
  localparam int PRICE_W              = 9;
  localparam int TOTAL_W              = 8;
  localparam int Q_W                  = 7;
  localparam int RECIP_SHIFT          = 14;
  localparam int PROD_W               = PRICE_W + RECIP_SHIFT;

  // Reciprocal of five scaled by 2^14; exact quotient for any 9-bit price.
  localparam logic [PROD_W-1:0] PRICE_RECIP = PROD_W'(3277);

  // Denominations in 5-cent units: 5, 10, 20, 50, 100, 200 cents.
  localparam logic [5:0] DENOM_UNITS [NUM_DENOMS] = '{
    6'd1, 6'd2, 6'd4, 6'd10, 6'd20, 6'd40
  };

  localparam logic [PAY_W-1:0] PAY_UNREACH = '1;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_CHG,
    ST_IDLE,
    ST_CLR,
    ST_PAY,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_FILL,
    OP_CLR,
    OP_CHG,
    OP_PAY,
    OP_SCAN
  } op_kind_t;

endpackage

`default_nettype wire

/* src/pay_and_change_min_coins_core.sv */
// Minimum coins paid plus change returned, over a table memory with one RMW pipeline.
//
//   channel | direction | ports                                      | transaction
//   in      | input     | in_valid, in_stall, in_count_*, in_price_* | one purse and a price
//   out     | output    | out_valid, out_stall, out_total_coins, ... | one result
//
// After reset the table is filled and the change column built, with in_stall high;
// UNITS = AMOUNT_LIMIT_CENTS/5. Each item then needs a clear pass over all UNITS+1
// entries, one pass per clamped held coin of each denomination, and a scan from the
// price up to the limit; the single table read/modify/write per cycle sets its pace.
// One item is worked at a time; a finished result sits in the output register, so
// the next transaction is taken while out_stall holds the previous one.
`default_nettype none

module pay_and_change_min_coins_core #(
  parameter int AMOUNT_LIMIT_CENTS = pcmc_pkg::AMOUNT_LIMIT_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [6:0] in_count_5c,
  input  wire logic [5:0] in_count_10c,
  input  wire logic [4:0] in_count_20c,
  input  wire logic [3:0] in_count_50c,
  input  wire logic [2:0] in_count_100c,
  input  wire logic [1:0] in_count_200c,
  input  wire logic [8:0] in_price_cents,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_total_coins,
  output logic            out_impossible
);

  import pcmc_pkg::*;

  localparam int UNITS = AMOUNT_LIMIT_CENTS / CENTS_PER_UNIT;
  localparam int DEPTH = UNITS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int W     = AW + PAY_W;
  localparam int SW    = ((AW > PAY_W) ? AW : PAY_W) + 1;
  localparam int CAP0  = UNITS / int'(DENOM_UNITS[0]);
  localparam int CAP1  = UNITS / int'(DENOM_UNITS[1]);
  localparam int CAP2  = UNITS / int'(DENOM_UNITS[2]);
  localparam int CAP3  = UNITS / int'(DENOM_UNITS[3]);
  localparam int CAP4  = UNITS / int'(DENOM_UNITS[4]);
  localparam int CAP5  = UNITS / int'(DENOM_UNITS[5]);

  localparam logic [AW-1:0] LAST_ADDR = AW'(UNITS);
  localparam logic [2:0]    LAST_K    = 3'(NUM_DENOMS - 1);

  typedef struct packed {
    logic           vld;
    op_kind_t       kind;
    logic [AW-1:0]  a;
    logic [AW-1:0]  b;
  } s1_t;

  // Word layout: change count in the upper bits, fewest held coins in the lower byte.
  logic [W-1:0] mem [DEPTH];

  state_t             state_r, state_nxt;
  logic [AW-1:0]      j_r, j_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   cnt_r [NUM_DENOMS];
  logic [CNT_W-1:0]   cnt_in [NUM_DENOMS];
  logic [PRICE_W-1:0] price_r;

  s1_t                s1_r, s1_nxt;
  logic [W-1:0]       rd_a_r, rd_b_r;
  logic               fwd_vld_r;
  logic [AW-1:0]      fwd_addr_r;
  logic [W-1:0]       fwd_data_r;

  logic [SW-1:0]      best_r;
  logic               found_r;
  logic               out_valid_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_imp_r;

  logic               in_acc;
  logic               out_load;
  logic [2:0]         kp1;
  logic [AW-1:0]      d_cur;
  logic [AW-1:0]      d_next;

  logic [PROD_W-1:0]  price_prod;
  logic [Q_W-1:0]     price_q;
  logic [PRICE_W-1:0] price_q5;
  logic [AW+Q_W-1:0]  p_wide;
  logic [AW-1:0]      p_units;
  logic               price_ok;

  logic [W-1:0]       da, db;
  logic [AW-1:0]      chg_a, chg_b;
  logic [PAY_W-1:0]   pay_a, pay_b;
  logic [AW:0]        chg_inc;
  logic [PAY_W:0]     pay_inc;
  logic [PAY_W-1:0]   pay_init;
  logic               we;
  logic [W-1:0]       wd;
  logic [SW-1:0]      tsum;
  logic               scan_hit;

  // ---------------------------------------------------------------- input side
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    cnt_in[0] = (int'(in_count_5c)   > CAP0) ? CNT_W'(CAP0) : in_count_5c;
    cnt_in[1] = (int'(in_count_10c)  > CAP1) ? CNT_W'(CAP1) : CNT_W'(in_count_10c);
    cnt_in[2] = (int'(in_count_20c)  > CAP2) ? CNT_W'(CAP2) : CNT_W'(in_count_20c);
    cnt_in[3] = (int'(in_count_50c)  > CAP3) ? CNT_W'(CAP3) : CNT_W'(in_count_50c);
    cnt_in[4] = (int'(in_count_100c) > CAP4) ? CNT_W'(CAP4) : CNT_W'(in_count_100c);
    cnt_in[5] = (int'(in_count_200c) > CAP5) ? CNT_W'(CAP5) : CNT_W'(in_count_200c);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cnt_r   <= cnt_in;
      price_r <= in_price_cents;
    end
  end

  // Price in 5-cent units; a price off the 5-cent grid or above the limit has no payment.
  assign price_prod = PROD_W'(price_r) * PRICE_RECIP;
  assign price_q    = price_prod[RECIP_SHIFT +: Q_W];
  assign price_q5   = {price_q, 2'b00} + {2'b00, price_q};
  assign p_wide     = (AW+Q_W)'(price_q);
  assign p_units    = p_wide[AW-1:0];
  assign price_ok   = (price_r == price_q5) && (int'(price_r) <= AMOUNT_LIMIT_CENTS);

  // ---------------------------------------------------------------- sequencer
  assign kp1    = k_r + 3'd1;
  assign d_cur  = AW'(DENOM_UNITS[k_r]);
  assign d_next = AW'(DENOM_UNITS[kp1]);

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    case (state_r)
      ST_FILL: begin
        if (j_r == LAST_ADDR) begin
          state_nxt = ST_CHG;
          k_nxt     = 3'd1;
          j_nxt     = AW'(DENOM_UNITS[1]);
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      ST_CHG: begin
        if (j_r == LAST_ADDR) begin
          if (k_r == LAST_K) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = kp1;
            j_nxt = d_next;
          end
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CLR;
          j_nxt     = '0;
        end
      end
      ST_CLR: begin
        if (j_r == LAST_ADDR) begin
          state_nxt = ST_PAY;
          k_nxt     = '0;
          n_nxt     = cnt_r[0];
          j_nxt     = LAST_ADDR;
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      ST_PAY: begin
        if (n_r == '0) begin
          // advance to the next denomination, or leave once all are spent
          if (k_r == LAST_K) begin
            if (price_ok) begin
              state_nxt = ST_SCAN;
              j_nxt     = p_units;
            end else begin
              state_nxt = ST_DRAIN;
            end
          end else begin
            k_nxt = kp1;
            n_nxt = cnt_r[kp1];
            j_nxt = LAST_ADDR;
          end
        end else if (j_r == d_cur) begin
          j_nxt = LAST_ADDR;
          n_nxt = n_r - CNT_W'(1);
        end else begin
          j_nxt = j_r - AW'(1);
        end
      end
      ST_SCAN: begin
        if (j_r == LAST_ADDR) begin
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s1_nxt      = '0;
    s1_nxt.kind = OP_FILL;
    s1_nxt.a    = j_r;
    s1_nxt.b    = j_r;
    in_stall    = 1'b1;
    out_load    = 1'b0;
    case (state_r)
      ST_FILL: begin
        s1_nxt.vld = 1'b1;
      end
      ST_CHG: begin
        s1_nxt.vld  = 1'b1;
        s1_nxt.kind = OP_CHG;
        s1_nxt.b    = j_r - d_cur;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_CLR: begin
        s1_nxt.vld  = 1'b1;
        s1_nxt.kind = OP_CLR;
      end
      ST_PAY: begin
        s1_nxt.vld  = (n_r != '0);
        s1_nxt.kind = OP_PAY;
        s1_nxt.b    = j_r - d_cur;
      end
      ST_SCAN: begin
        s1_nxt.vld  = 1'b1;
        s1_nxt.kind = OP_SCAN;
        s1_nxt.b    = j_r - p_units;
      end
      ST_OUT: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      j_r     <= '0;
      k_r     <= '0;
      n_r     <= '0;
      s1_r    <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
      s1_r    <= s1_nxt;
    end
  end

  // ---------------------------------------------------------------- table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[s1_r.a] <= wd;
    end
    rd_a_r <= mem[s1_nxt.a];
    rd_b_r <= mem[s1_nxt.b];
  end

  // Capture the write that lands on the same edge as a read; that read sees stale data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else begin
      fwd_vld_r <= we;
    end
    fwd_addr_r <= s1_r.a;
    fwd_data_r <= wd;
  end

  // ---------------------------------------------------------------- modify stage
  assign da = (fwd_vld_r && fwd_addr_r == s1_r.a) ? fwd_data_r : rd_a_r;
  assign db = (fwd_vld_r && fwd_addr_r == s1_r.b) ? fwd_data_r : rd_b_r;

  assign chg_a    = da[W-1:PAY_W];
  assign pay_a    = da[PAY_W-1:0];
  assign chg_b    = db[W-1:PAY_W];
  assign pay_b    = db[PAY_W-1:0];
  assign chg_inc  = {1'b0, chg_b} + (AW+1)'(1);
  assign pay_inc  = {1'b0, pay_b} + (PAY_W+1)'(1);
  assign pay_init = (s1_r.a == '0) ? '0 : PAY_UNREACH;
  assign tsum     = SW'(pay_a) + SW'(chg_b);

  always_comb begin
    we = s1_r.vld;
    wd = da;
    case (s1_r.kind)
      OP_FILL: begin
        wd = {s1_r.a, pay_init};
      end
      OP_CLR: begin
        wd = {chg_a, pay_init};
      end
      OP_CHG: begin
        wd = {(chg_inc < {1'b0, chg_a}) ? chg_inc[AW-1:0] : chg_a, pay_a};
      end
      OP_PAY: begin
        wd = {chg_a, (pay_b != PAY_UNREACH && pay_inc < {1'b0, pay_a}) ?
                     pay_inc[PAY_W-1:0] : pay_a};
      end
      OP_SCAN: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign scan_hit = s1_r.vld && s1_r.kind == OP_SCAN && pay_a != PAY_UNREACH &&
                    (!found_r || tsum < best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (in_acc) begin
      found_r <= 1'b0;
    end else if (scan_hit) begin
      found_r <= 1'b1;
    end
    if (scan_hit) begin
      best_r <= tsum;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_imp_r <= !found_r;
      if (!found_r) begin
        out_total_r <= '0;
      end else if (best_r > SW'({TOTAL_W{1'b1}})) begin
        out_total_r <= '1;
      end else begin
        out_total_r <= best_r[TOTAL_W-1:0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_total_coins = out_total_r;
  assign out_impossible  = out_imp_r;

endmodule

`default_nettype wire

/* src/pcmc_checker.sv */
// Port-level checks for the pay-and-change core, bound to its top level.
`default_nettype none

module pcmc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_total_coins,
  input wire logic       out_impossible
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_total_coins) && $stable(out_impossible))
    else $error("result changed while stalled");

  // an unpayable price reports no coins
  a_imp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_impossible |-> out_total_coins == 8'd0)
    else $error("impossible result with nonzero coin count");

  // one transaction at a time: the block is busy right after it takes one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  // a new result is posted on the way back to idle
  a_post_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result posted while still busy");

endmodule

bind pay_and_change_min_coins_core pcmc_checker u_pcmc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_total_coins (out_total_coins),
  .out_impossible  (out_impossible)
);

`default_nettype wire

/* bench/pay_and_change_min_coins_core_tb.sv */
// Self-checking testbench for the pay-and-change minimum coin block.
module pay_and_change_min_coins_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CENTS = 500;
  localparam int UNITS = LIMIT_CENTS / 5;
  localparam int COIN_UNITS [6] = '{1, 2, 4, 10, 20, 40};
  localparam int HOLD_OFF_CYCLES = 4000;
  localparam int BURST_PURSES = 8;
  localparam int RANDOM_PURSES = 70;
  localparam int TAIL_CYCLES = 200;

  typedef enum int {
    SPREAD_TINY,
    SPREAD_SMALL,
    SPREAD_FULL
  } spread_t;

  typedef struct packed {
    logic [6:0] n5;
    logic [5:0] n10;
    logic [4:0] n20;
    logic [3:0] n50;
    logic [2:0] n100;
    logic [1:0] n200;
    logic [8:0] price;
  } purse_t;

  typedef struct packed {
    logic [7:0] total;
    logic       impossible;
  } exchange_t;

  typedef struct packed {
    purse_t    purse;
    logic      known;
    exchange_t want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [6:0] in_count_5c;
  logic [5:0] in_count_10c;
  logic [4:0] in_count_20c;
  logic [3:0] in_count_50c;
  logic [2:0] in_count_100c;
  logic [1:0] in_count_200c;
  logic [8:0] in_price_cents;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_total_coins;
  logic       out_impossible;

  int unsigned change_coins [0:UNITS];
  exchange_t   owed_results [$];
  stim_row_t   directed [$];
  bit          hold_req = 1'b0;
  int          mismatches = 0;
  int          n_sent = 0;
  int          n_wide = 0;
  int          n_checked = 0;
  int          n_impossible = 0;
  int          n_in_stalled = 0;

  pay_and_change_min_coins_core #(
    .AMOUNT_LIMIT_CENTS(LIMIT_CENTS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_count_5c    (in_count_5c),
    .in_count_10c   (in_count_10c),
    .in_count_20c   (in_count_20c),
    .in_count_50c   (in_count_50c),
    .in_count_100c  (in_count_100c),
    .in_count_200c  (in_count_200c),
    .in_price_cents (in_price_cents),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_total_coins(out_total_coins),
    .out_impossible (out_impossible)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fewest coins for each change amount from an unlimited supply.
  initial begin : change_rows
    for (int j = 0; j <= UNITS; j++) change_coins[j] = j;
    for (int k = 1; k < 6; k++) begin
      for (int j = COIN_UNITS[k]; j <= UNITS; j++) begin
        if (change_coins[j - COIN_UNITS[k]] + 1 < change_coins[j]) begin
          change_coins[j] = change_coins[j - COIN_UNITS[k]] + 1;
        end
      end
    end
  end

  function automatic exchange_t min_coins_exchanged(purse_t p);
    int unsigned fewest [0:UNITS];
    bit          reach [0:UNITS];
    int unsigned held [6];
    int unsigned quota;
    int unsigned best;
    int unsigned t;
    int unsigned pu;
    bit          found;
    exchange_t   r;
    held[0] = p.n5;
    held[1] = p.n10;
    held[2] = p.n20;
    held[3] = p.n50;
    held[4] = p.n100;
    held[5] = p.n200;
    for (int j = 0; j <= UNITS; j++) begin
      fewest[j] = 0;
      reach[j] = 1'b0;
    end
    reach[0] = 1'b1;
    best = 0;
    found = 1'b0;
    // Bounded knapsack: each held coin is one more 0/1 pass over the amounts.
    for (int k = 0; k < 6; k++) begin
      quota = held[k];
      if (quota > UNITS / COIN_UNITS[k]) quota = UNITS / COIN_UNITS[k];
      for (int n = 0; n < quota; n++) begin
        for (int j = UNITS; j >= COIN_UNITS[k]; j--) begin
          if (reach[j - COIN_UNITS[k]]) begin
            t = fewest[j - COIN_UNITS[k]] + 1;
            if (!reach[j] || t < fewest[j]) begin
              fewest[j] = t;
              reach[j] = 1'b1;
            end
          end
        end
      end
    end
    if (p.price % 5 == 0 && p.price <= LIMIT_CENTS) begin
      pu = p.price / 5;
      for (int j = pu; j <= UNITS; j++) begin
        if (reach[j]) begin
          t = fewest[j] + change_coins[j - pu];
          if (!found || t < best) begin
            best = t;
            found = 1'b1;
          end
        end
      end
    end
    if (found) begin
      r.total = (best > 255) ? 8'd255 : 8'(best);
      r.impossible = 1'b0;
    end else begin
      r.total = 8'd0;
      r.impossible = 1'b1;
    end
    return r;
  endfunction

  // A negative fixed_total leaves the row to the predictor.
  function automatic stim_row_t mk_row(input int n5, n10, n20, n50, n100, n200, price,
                                       input int fixed_total, fixed_imp);
    stim_row_t r;
    r.purse.n5 = 7'(n5);
    r.purse.n10 = 6'(n10);
    r.purse.n20 = 5'(n20);
    r.purse.n50 = 4'(n50);
    r.purse.n100 = 3'(n100);
    r.purse.n200 = 2'(n200);
    r.purse.price = 9'(price);
    r.known = (fixed_total >= 0);
    r.want.total = 8'(fixed_total);
    r.want.impossible = 1'(fixed_imp);
    return r;
  endfunction

  function automatic purse_t random_purse(spread_t spread);
    purse_t p;
    int     lim;
    if (spread == SPREAD_FULL) begin
      p.n5 = 7'($urandom);
      p.n10 = 6'($urandom);
      p.n20 = 5'($urandom);
      p.n50 = 4'($urandom);
      p.n100 = 3'($urandom);
      p.n200 = 2'($urandom);
    end else begin
      lim = (spread == SPREAD_TINY) ? 1 : 6;
      p.n5 = 7'($urandom_range(0, lim));
      p.n10 = 6'($urandom_range(0, lim));
      p.n20 = 5'($urandom_range(0, lim));
      p.n50 = 4'($urandom_range(0, 3));
      p.n100 = 3'($urandom_range(0, 2));
      p.n200 = 2'($urandom_range(0, 2));
    end
    // Mostly payable prices; the rest cover odd and out-of-range values.
    if ($urandom_range(0, 4) == 0) p.price = 9'($urandom_range(0, 511));
    else p.price = 9'($urandom_range(0, UNITS) * 5);
    return p;
  endfunction

  function automatic int draw_gap(bit steady);
    return steady ? 0 : int'($urandom_range(0, 18));
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Entered at a falling edge; returns at the falling edge after the transaction.
  task automatic offer_purse(purse_t p, int gap, bit known, exchange_t want);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_count_5c <= p.n5;
    in_count_10c <= p.n10;
    in_count_20c <= p.n20;
    in_count_50c <= p.n50;
    in_count_100c <= p.n100;
    in_count_200c <= p.n200;
    in_price_cents <= p.price;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) begin
      n_in_stalled++;
      @(posedge clk);
    end
    owed_results.insert(owed_results.size(), known ? want : min_coins_exchanged(p));
    n_sent++;
    @(negedge clk);
  endtask

  initial begin : purse_source
    stim_row_t row;
    bit        steady;
    spread_t   spread;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_count_5c = '0;
    in_count_10c = '0;
    in_count_20c = '0;
    in_count_50c = '0;
    in_count_100c = '0;
    in_count_200c = '0;
    in_price_cents = '0;
    steady = 1'b0;

    directed.insert(directed.size(), mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.insert(directed.size(), mk_row(0, 0, 0, 0, 0, 0, 5, 0, 1));
    directed.insert(directed.size(), mk_row(1, 0, 0, 0, 0, 0, 5, 1, 0));
    directed.insert(directed.size(), mk_row(0, 0, 0, 0, 0, 1, 200, 1, 0));
    directed.insert(directed.size(), mk_row(127, 0, 0, 0, 0, 0, 500, 100, 0));
    directed.insert(directed.size(), mk_row(10, 10, 10, 10, 5, 2, 7, 0, 1));
    directed.insert(directed.size(), mk_row(10, 10, 10, 10, 5, 2, 505, 0, 1));
    directed.insert(directed.size(), mk_row(127, 63, 31, 15, 7, 3, 511, 0, 1));
    directed.insert(directed.size(), mk_row(127, 63, 31, 15, 7, 3, 500, 3, 0));
    directed.insert(directed.size(), mk_row(127, 63, 31, 15, 7, 3, 0, 0, 0));
    directed.insert(directed.size(), mk_row(0, 0, 0, 0, 0, 2, 5, -1, 0));
    directed.insert(directed.size(), mk_row(0, 0, 0, 0, 0, 3, 500, 0, 1));
    directed.insert(directed.size(), mk_row(0, 0, 0, 0, 7, 0, 500, 5, 0));
    directed.insert(directed.size(), mk_row(0, 0, 0, 15, 0, 0, 500, 10, 0));
    directed.insert(directed.size(), mk_row(0, 0, 31, 0, 0, 0, 500, 25, 0));
    directed.insert(directed.size(), mk_row(0, 63, 0, 0, 0, 0, 500, 50, 0));
    directed.insert(directed.size(), mk_row(3, 2, 1, 1, 1, 1, 135, -1, 0));
    directed.insert(directed.size(), mk_row(0, 0, 0, 1, 0, 0, 15, -1, 0));
    directed.insert(directed.size(), mk_row(5, 0, 0, 0, 0, 0, 30, 0, 1));
    directed.insert(directed.size(), mk_row(0, 0, 0, 0, 1, 1, 295, -1, 0));
    directed.insert(directed.size(), mk_row(64, 32, 16, 8, 4, 0, 260, -1, 0));
    directed.insert(directed.size(), mk_row(2, 1, 0, 0, 0, 0, 20, -1, 0));
    directed.insert(directed.size(), mk_row(0, 5, 0, 0, 0, 0, 45, 6, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      row = directed[i];
      offer_purse(row.purse, draw_gap(1'b0), row.known, row.want);
    end

    // Drain everything before the back-pressure burst.
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    @(negedge clk);

    // Sink holds off while cheap purses keep coming, so the block backs up.
    hold_req = 1'b1;
    repeat (BURST_PURSES) offer_purse(random_purse(SPREAD_TINY), 0, 1'b0, '0);

    for (int i = 0; i < RANDOM_PURSES; i++) begin
      if ($urandom_range(0, 11) == 0) steady = !steady;
      spread = ($urandom_range(0, 9) == 0) ? SPREAD_FULL : SPREAD_SMALL;
      if (spread == SPREAD_FULL) n_wide++;
      offer_purse(random_purse(spread), draw_gap(steady), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d purses (%0d directed, %0d with full-range counts), %0d results,",
             n_sent, directed.size(), n_wide, n_checked);
    $display("%0d of them unpayable; input held back %0d cycles, one %0d-cycle sink hold-off.",
             n_impossible, n_in_stalled, HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_sink
    int        stall_left;
    int        hold_left;
    bit        steady;
    exchange_t want;
    out_stall = 1'b0;
    steady = 1'b0;
    hold_left = 0;
    stall_left = draw_gap(steady);
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1) begin
        if (!out_stall) begin
          n_checked++;
          if (out_impossible === 1'b1) n_impossible++;
          if (owed_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result total=%0d impossible=%0b",
                                      out_total_coins, out_impossible));
          end else begin
            want = owed_results.pop_front();
            if (out_total_coins !== want.total) begin
              report_mismatch($sformatf("total_coins got %0d, want %0d",
                                        out_total_coins, want.total));
            end
            if (out_impossible !== want.impossible) begin
              report_mismatch($sformatf("impossible got %0b, want %0b",
                                        out_impossible, want.impossible));
            end
          end
          if ($urandom_range(0, 11) == 0) steady = !steady;
          stall_left = draw_gap(steady);
        end else if (stall_left > 0) begin
          stall_left--;
        end
      end
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      @(negedge clk);
      out_stall <= (hold_left > 0) || (stall_left > 0);
    end
  end

  initial begin : watchdog
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
